FILE: src/assert_macros.svh
// assertion macros shared by the frame receiver modules
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every clock edge outside reset
`define AST_HOLDS(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("assertion failed");

// condition must never be seen at a clock edge outside reset
`define AST_NEVER(lbl, clk, rst_n, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("forbidden condition seen");

`endif

FILE: src/lfr_pkg.sv
// types, constants and crc function of the frame receiver
`default_nettype none

package lfr_pkg;

  localparam int unsigned CNT_W      = 7;
  localparam int unsigned MIN_FRAME  = 7;
  localparam int unsigned HDR_LEN    = 5;
  localparam int unsigned ACK_LEN    = 7;
  localparam int unsigned ACK_CRC_N  = 5;
  localparam logic [15:0] CRC_INIT   = 16'hFFFF;
  localparam logic [15:0] CRC_POLY   = 16'h1021;
  localparam logic [15:0] CRC_MSB    = 16'h8000;

  localparam logic [7:0] RST_LOCAL_ID  = 8'd0;
  localparam logic [7:0] RST_BCAST_ID  = 8'd255;
  localparam logic [7:0] RST_ACK_MASK  = 8'd1;
  localparam logic [7:0] RST_ACK_FLAG  = 8'd2;
  localparam logic [7:0] RST_HOST_MAX  = 8'd41;

  typedef enum logic [1:0] {
    KIND_PAY  = 2'd0,
    KIND_STAT = 2'd1,
    KIND_ACK  = 2'd2
  } kind_e;

  typedef enum logic [2:0] {
    FS_OK        = 3'd0,
    FS_SHORT     = 3'd1,
    FS_NOT_ADDR  = 3'd2,
    FS_LEN_BAD   = 3'd3,
    FS_CRC_BAD   = 3'd4
  } fstat_e;

  typedef enum logic [2:0] {
    CFG_LOCAL_ID = 3'd0,
    CFG_BCAST_ID = 3'd1,
    CFG_ACK_MASK = 3'd2,
    CFG_ACK_FLAG = 3'd3,
    CFG_HOST_MAX = 3'd4
  } cfg_idx_e;

  // controller to datapath
  typedef struct packed {
    logic  rx_take;
    logic  eval;
    logic  cnt_clr;
    logic  cnt_inc;
    logic  crc_step;
    logic  crc_clr;
    logic  load_out;
    kind_e out_kind;
    logic  out_last;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic out_free;
    logic want_ack;
    logic pay_done;
    logic crc_done;
    logic ack_last;
  } sts_t;

  // one byte of crc-16, msb first
  function automatic logic [15:0] crc_feed(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int k = 0; k < 8; k++) begin
      if ((c & CRC_MSB) != 16'h0000) begin
        c = {c[14:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[14:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

`default_nettype wire

FILE: src/lfr_ctrl.sv
// controller state machine of the frame receiver
`default_nettype none
`include "assert_macros.svh"

module lfr_ctrl (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  output logic               in_ready_o,
  input  wire logic          end_of_frame_i,
  input  wire lfr_pkg::sts_t sts_i,
  output lfr_pkg::cmd_t      cmd_o
);
  import lfr_pkg::*;

  typedef enum logic [5:0] {
    ST_RX     = 6'b000001,
    ST_EVAL   = 6'b000010,
    ST_PAY    = 6'b000100,
    ST_STAT   = 6'b001000,
    ST_ACKCRC = 6'b010000,
    ST_ACK    = 6'b100000
  } state_e;

  state_e state_q, state_d;

  assign in_ready_o = (state_q == ST_RX);

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    cmd_o.out_kind = KIND_STAT;
    case (state_q)
      ST_RX: begin
        if (in_valid_i) begin
          cmd_o.rx_take = 1'b1;
          if (end_of_frame_i) begin
            state_d = ST_EVAL;
          end
        end
      end
      ST_EVAL: begin
        cmd_o.eval    = 1'b1;
        cmd_o.cnt_clr = 1'b1;
        state_d       = ST_PAY;
      end
      ST_PAY: begin
        if (sts_i.pay_done) begin
          state_d = ST_STAT;
        end else if (sts_i.out_free) begin
          cmd_o.load_out = 1'b1;
          cmd_o.out_kind = KIND_PAY;
          cmd_o.cnt_inc  = 1'b1;
        end
      end
      ST_STAT: begin
        if (sts_i.out_free) begin
          cmd_o.load_out = 1'b1;
          cmd_o.out_kind = KIND_STAT;
          cmd_o.out_last = !sts_i.want_ack;
          cmd_o.cnt_clr  = 1'b1;
          state_d        = sts_i.want_ack ? ST_ACKCRC : ST_RX;
        end
      end
      ST_ACKCRC: begin
        cmd_o.crc_step = 1'b1;
        if (sts_i.crc_done) begin
          cmd_o.cnt_clr = 1'b1;
          state_d       = ST_ACK;
        end else begin
          cmd_o.cnt_inc = 1'b1;
        end
      end
      ST_ACK: begin
        if (sts_i.out_free) begin
          cmd_o.load_out = 1'b1;
          cmd_o.out_kind = KIND_ACK;
          cmd_o.cnt_inc  = 1'b1;
          if (sts_i.ack_last) begin
            cmd_o.out_last = 1'b1;
            cmd_o.crc_clr  = 1'b1;
            state_d        = ST_RX;
          end
        end
      end
      default: begin
        state_d = ST_RX;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_RX;
    end else begin
      state_q <= state_d;
    end
  end

  `AST_NEVER(a_load_busy, clk_i, rst_ni, cmd_o.load_out && !sts_i.out_free)
  `AST_HOLDS(a_ack_wanted, clk_i, rst_ni,
             (state_q == ST_ACKCRC || state_q == ST_ACK) |-> sts_i.want_ack)

endmodule

`default_nettype wire

FILE: src/lfr_dp.sv
// datapath of the frame receiver: store, crc, checks, output register
`default_nettype none
`include "assert_macros.svh"

module lfr_dp #(
  parameter int unsigned MAX_FRAME = 48
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          cfg_valid_i,
  input  wire logic [2:0]    cfg_index_i,
  input  wire logic [7:0]    cfg_data_i,
  input  wire logic [7:0]    rx_byte_i,
  input  wire lfr_pkg::cmd_t cmd_i,
  output lfr_pkg::sts_t      sts_o,
  input  wire logic          out_ready_i,
  output logic               out_valid_o,
  output logic [1:0]         kind_o,
  output logic [7:0]         data_byte_o,
  output logic [7:0]         source_id_o,
  output logic [7:0]         payload_length_o,
  output logic [2:0]         frame_status_o,
  output logic               last_o
);
  import lfr_pkg::*;

  localparam int unsigned AW = $clog2(MAX_FRAME);

  // configuration
  logic [7:0] local_id_q, bcast_id_q, ack_mask_q, ack_flag_q, host_max_q;

  // frame state
  logic [CNT_W-1:0] cnt_q;
  logic             ovf_q;
  logic [15:0]      crc_q, crc_d;
  logic [7:0]       dly0_q, dly1_q;
  logic [7:0]       dst_q, src_q, seq_q, flags_q, plen_q;
  logic [7:0]       mem [MAX_FRAME];
  logic [7:0]       rd_data_q;

  // verdict
  fstat_e     stat_q, stat_d;
  logic       want_ack_q, want_ack_d;
  logic [7:0] ncopy_q, ncopy_d;
  logic [7:0] rep_src_q, rep_plen_q;

  // item counter, payload index or ack byte index
  logic [7:0] pcnt_q, pcnt_d;
  logic [7:0] rd_pos;
  logic [7:0] ack_byte;

  // output register
  logic       ovalid_q;
  kind_e      okind_q;
  logic [7:0] odata_q, osrc_q, oplen_q;
  fstat_e     ostat_q;
  logic       olast_q;
  logic [7:0] odata_d;

  logic take_ok;
  logic too_short, dst_ok, len_bad, crc_bad;

  assign take_ok = cmd_i.rx_take && (cnt_q < CNT_W'(MAX_FRAME));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      local_id_q <= RST_LOCAL_ID;
      bcast_id_q <= RST_BCAST_ID;
      ack_mask_q <= RST_ACK_MASK;
      ack_flag_q <= RST_ACK_FLAG;
      host_max_q <= RST_HOST_MAX;
    end else if (cfg_valid_i) begin
      case (cfg_idx_e'(cfg_index_i))
        CFG_LOCAL_ID: local_id_q <= cfg_data_i;
        CFG_BCAST_ID: bcast_id_q <= cfg_data_i;
        CFG_ACK_MASK: ack_mask_q <= cfg_data_i;
        CFG_ACK_FLAG: ack_flag_q <= cfg_data_i;
        CFG_HOST_MAX: host_max_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // frame checks on the state left by the final byte
  always_comb begin
    too_short = (cnt_q < CNT_W'(MIN_FRAME));
    dst_ok    = (dst_q == local_id_q) || (dst_q == bcast_id_q);
    len_bad   = ovf_q || (({1'b0, plen_q} + 9'(MIN_FRAME)) != {2'b00, cnt_q});
    crc_bad   = ({dly0_q, dly1_q} != crc_q);
    if (too_short) begin
      stat_d = FS_SHORT;
    end else if (!dst_ok) begin
      stat_d = FS_NOT_ADDR;
    end else if (len_bad) begin
      stat_d = FS_LEN_BAD;
    end else if (crc_bad) begin
      stat_d = FS_CRC_BAD;
    end else begin
      stat_d = FS_OK;
    end
    want_ack_d = (stat_d == FS_OK) && ((flags_q & ack_mask_q) != 8'h00)
                 && (dst_q == local_id_q);
    if (stat_d != FS_OK) begin
      ncopy_d = 8'd0;
    end else if (plen_q > host_max_q) begin
      ncopy_d = host_max_q;
    end else begin
      ncopy_d = plen_q;
    end
  end

  // ack frame bytes; crc bytes come from the shared crc register
  always_comb begin
    case (pcnt_q[2:0])
      3'd0:    ack_byte = src_q;
      3'd1:    ack_byte = local_id_q;
      3'd2:    ack_byte = seq_q;
      3'd3:    ack_byte = ack_flag_q;
      3'd5:    ack_byte = crc_q[15:8];
      3'd6:    ack_byte = crc_q[7:0];
      default: ack_byte = 8'h00;
    endcase
  end

  always_comb begin
    crc_d = crc_q;
    if (cmd_i.eval || cmd_i.crc_clr) begin
      crc_d = CRC_INIT;
    end else if (cmd_i.rx_take && (cnt_q >= CNT_W'(2))) begin
      crc_d = crc_feed(crc_q, dly0_q);
    end else if (cmd_i.crc_step) begin
      crc_d = crc_feed(crc_q, ack_byte);
    end
  end

  always_comb begin
    pcnt_d = pcnt_q;
    if (cmd_i.cnt_clr) begin
      pcnt_d = 8'd0;
    end else if (cmd_i.cnt_inc) begin
      pcnt_d = pcnt_q + 8'd1;
    end
  end

  assign rd_pos = 8'(HDR_LEN) + pcnt_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q      <= '0;
      ovf_q      <= 1'b0;
      crc_q      <= CRC_INIT;
      dly0_q     <= 8'h00;
      dly1_q     <= 8'h00;
      pcnt_q     <= 8'd0;
      stat_q     <= FS_OK;
      want_ack_q <= 1'b0;
      ncopy_q    <= 8'd0;
    end else begin
      crc_q  <= crc_d;
      pcnt_q <= pcnt_d;
      if (cmd_i.eval) begin
        cnt_q      <= '0;
        ovf_q      <= 1'b0;
        dly0_q     <= 8'h00;
        dly1_q     <= 8'h00;
        stat_q     <= stat_d;
        want_ack_q <= want_ack_d;
        ncopy_q    <= ncopy_d;
      end else if (cmd_i.rx_take) begin
        if (!take_ok) begin
          ovf_q <= 1'b1;
        end
        dly0_q <= dly1_q;
        dly1_q <= rx_byte_i;
        if (cnt_q != {CNT_W{1'b1}}) begin
          cnt_q <= cnt_q + CNT_W'(1);
        end
      end
    end
  end

  // header bytes kept in flops
  always_ff @(posedge clk_i) begin
    if (cmd_i.rx_take) begin
      if (cnt_q == CNT_W'(0)) dst_q   <= rx_byte_i;
      if (cnt_q == CNT_W'(1)) src_q   <= rx_byte_i;
      if (cnt_q == CNT_W'(2)) seq_q   <= rx_byte_i;
      if (cnt_q == CNT_W'(3)) flags_q <= rx_byte_i;
      if (cnt_q == CNT_W'(4)) plen_q  <= rx_byte_i;
    end
    if (cmd_i.eval) begin
      rep_src_q  <= too_short ? 8'h00 : src_q;
      rep_plen_q <= too_short ? 8'h00 : plen_q;
    end
  end

  // frame store, one write and one registered read per cycle
  always_ff @(posedge clk_i) begin
    if (take_ok) begin
      mem[cnt_q[AW-1:0]] <= rx_byte_i;
    end
    if (rd_pos < 8'(MAX_FRAME)) begin
      rd_data_q <= mem[rd_pos[AW-1:0]];
    end
  end

  always_comb begin
    case (cmd_i.out_kind)
      KIND_PAY: odata_d = rd_data_q;
      KIND_ACK: odata_d = ack_byte;
      default:  odata_d = 8'h00;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ovalid_q <= 1'b0;
    end else if (cmd_i.load_out) begin
      ovalid_q <= 1'b1;
    end else if (out_ready_i) begin
      ovalid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      okind_q <= cmd_i.out_kind;
      odata_q <= odata_d;
      osrc_q  <= rep_src_q;
      oplen_q <= rep_plen_q;
      ostat_q <= stat_q;
      olast_q <= cmd_i.out_last;
    end
  end

  assign sts_o.out_free = !ovalid_q || out_ready_i;
  assign sts_o.want_ack = want_ack_q;
  assign sts_o.pay_done = (pcnt_q == ncopy_q);
  assign sts_o.crc_done = (pcnt_q == 8'(ACK_CRC_N - 1));
  assign sts_o.ack_last = (pcnt_q == 8'(ACK_LEN - 1));

  assign out_valid_o      = ovalid_q;
  assign kind_o           = okind_q;
  assign data_byte_o      = odata_q;
  assign source_id_o      = osrc_q;
  assign payload_length_o = oplen_q;
  assign frame_status_o   = ostat_q;
  assign last_o           = olast_q;

  `AST_HOLDS(a_pay_only_ok, clk_i, rst_ni,
             (ovalid_q && (okind_q == KIND_PAY)) |-> (stat_q == FS_OK))
  `AST_HOLDS(a_eval_clears, clk_i, rst_ni,
             cmd_i.eval |=> ((cnt_q == '0) && (crc_q == CRC_INIT) && !ovf_q))

endmodule

`default_nettype wire

FILE: src/link_frame_receiver_with_ack_core.sv
// top level of the link frame receiver with ack generation
`default_nettype none

// channel   direction  handshake                 payload
// in        request    in_valid_i / in_ready_o   rx_byte_i, end_of_frame_i
// out       result     out_valid_o / out_ready_i kind_o, data_byte_o, source_id_o,
//                                                 payload_length_o, frame_status_o, last_o
// cfg       write      cfg_valid_i / cfg_ready_o cfg_index_i, cfg_data_i
//
// one byte request per cycle while receiving; crc advances one byte per cycle
// after the final byte: a check step, one payload result per cycle while the output is free,
// an idle step, the status result, then the ack crc over five bytes and seven ack bytes
// a stalled output holds the sequencer; the receive side reopens once the
// final result of a frame sits in the output register
// reset clears control and frame state; the frame store needs no clearing

module link_frame_receiver_with_ack_core #(
  parameter int unsigned MAX_FRAME = 48
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  // byte requests
  input  wire logic       in_valid_i,
  output logic            in_ready_o,
  input  wire logic [7:0] rx_byte_i,
  input  wire logic       end_of_frame_i,
  // result items
  output logic            out_valid_o,
  input  wire logic       out_ready_i,
  output logic [1:0]      kind_o,
  output logic [7:0]      data_byte_o,
  output logic [7:0]      source_id_o,
  output logic [7:0]      payload_length_o,
  output logic [2:0]      frame_status_o,
  output logic            last_o,
  // register writes
  input  wire logic       cfg_valid_i,
  output logic            cfg_ready_o,
  input  wire logic [2:0] cfg_index_i,
  input  wire logic [7:0] cfg_data_i
);
  import lfr_pkg::*;

  cmd_t cmd;
  sts_t sts;

  // registers are always writable
  assign cfg_ready_o = 1'b1;

  // sequencer: receive, check, payload, status, ack crc, ack bytes
  lfr_ctrl u_ctrl (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .end_of_frame_i (end_of_frame_i),
    .sts_i          (sts),
    .cmd_o          (cmd)
  );

  // store, header flops, shared crc unit, verdict and output register
  lfr_dp #(
    .MAX_FRAME (MAX_FRAME)
  ) u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_valid_i      (cfg_valid_i),
    .cfg_index_i      (cfg_index_i),
    .cfg_data_i       (cfg_data_i),
    .rx_byte_i        (rx_byte_i),
    .cmd_i            (cmd),
    .sts_o            (sts),
    .out_ready_i      (out_ready_i),
    .out_valid_o      (out_valid_o),
    .kind_o           (kind_o),
    .data_byte_o      (data_byte_o),
    .source_id_o      (source_id_o),
    .payload_length_o (payload_length_o),
    .frame_status_o   (frame_status_o),
    .last_o           (last_o)
  );

endmodule

`default_nettype wire
